[design/fpt_pkg.sv]
// Shared types, codes and defaults for the flat page table engine.
`default_nettype none

package fpt_pkg;

    localparam int ADDR_BITS  = 48;
    localparam int COUNT_BITS = 17;
    localparam int BYTE_BITS  = 8;
    localparam int FUNC_BITS  = 3;

    localparam int PAGE_SHIFT_DEF     = 12;
    localparam int TABLE_PAGES_DEF    = 65536;
    localparam int HOST_ADDR_BITS_DEF = 48;

    // Request selector codes
    localparam logic [FUNC_BITS-1:0] FUNC_MAP       = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_REMAP     = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_UNMAP     = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_PROTECT   = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_ATTR      = 3'd4;
    localparam logic [FUNC_BITS-1:0] FUNC_TRANSLATE = 3'd5;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY     = 3'd6;

    typedef struct packed {
        logic [FUNC_BITS-1:0]  func;
        logic [ADDR_BITS-1:0]  va;
        logic [ADDR_BITS-1:0]  src_va;
        logic [COUNT_BITS-1:0] run_pages;
        logic [ADDR_BITS-1:0]  host_base;
        logic [BYTE_BITS-1:0]  state_type;
        logic [BYTE_BITS-1:0]  perm;
        logic [BYTE_BITS-1:0]  attr_value;
        logic [BYTE_BITS-1:0]  attr_mask;
    } fpt_in_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] host_addr;
        logic [ADDR_BITS-1:0] region_base;
        logic [BYTE_BITS-1:0] out_type;
        logic [BYTE_BITS-1:0] out_perm;
        logic [BYTE_BITS-1:0] out_attr;
        logic                 range_fault;
    } fpt_out_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;   // zero one entry of the clearing pass
        logic load;       // capture a new request
        logic rd;         // issue a table read
        logic wr;         // write back the updated entry
        logic adv;        // step to the next page of the run
        logic set_fault;  // flag a page beyond the table
        logic done;       // load the result register
    } fpt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic range_op;
        logic lookup_op;
        logic count_zero;
        logic page_out;
        logic out_free;
    } fpt_sts_t;

endpackage

`default_nettype wire

[design/flat_page_table_engine.sv]
// Flat page table engine: one entry per virtual page, walked by a controller/datapath pair.
// Lookups (translate, query): one registered table read, then the result beat.
// Range requests: one read-modify-write of the table memory per page inside the table
//   (read, then write-back); a run stops at the first page beyond the table.
// One request at a time; a result waiting in the output register does not block intake.
// Reset: clears every entry of the table in a clearing pass, with in_ready low meanwhile.
`default_nettype none

module flat_page_table_engine #(
    parameter int PAGE_SHIFT     = fpt_pkg::PAGE_SHIFT_DEF,
    parameter int TABLE_PAGES    = fpt_pkg::TABLE_PAGES_DEF,
    parameter int HOST_ADDR_BITS = fpt_pkg::HOST_ADDR_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fpt_pkg::fpt_in_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output fpt_pkg::fpt_out_t     out_data
);

    // Command and status between the sequencer and the table datapath
    fpt_pkg::fpt_cmd_t cmd;
    fpt_pkg::fpt_sts_t sts;

    // Sequencer: runs the clearing pass after reset, takes one request beat,
    // walks range requests page by page (read, then write back) and hands
    // the result to the output register once that register is free.
    fpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: holds the request, the page table memory with its registered
    // read port, the per-page entry update and the output beat register.
    fpt_dpath #(
        .PAGE_SHIFT     (PAGE_SHIFT),
        .TABLE_PAGES    (TABLE_PAGES),
        .HOST_ADDR_BITS (HOST_ADDR_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

[design/fpt_ctrl.sv]
// Controller state machine: clearing pass, request intake, page walk, result hand-off.
`default_nettype none

module fpt_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire fpt_pkg::fpt_sts_t sts,
    output fpt_pkg::fpt_cmd_t     cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WRITE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (sts.range_op)
                begin
                    if (sts.count_zero)
                    begin
                        state_next = S_FIN;
                    end
                    else if (sts.page_out)
                    begin
                        // every later page lies beyond the table too: flag and stop
                        cmd.set_fault = 1'b1;
                        state_next    = S_FIN;
                    end
                    else
                    begin
                        cmd.rd     = 1'b1;
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    cmd.rd     = sts.lookup_op;
                    state_next = S_FIN;
                end
            end
            S_WRITE:
            begin
                cmd.wr     = 1'b1;
                cmd.adv    = 1'b1;
                state_next = S_READ;
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> $past(cmd.rd))
        else $error("write-back without a preceding table read");

    a_clear_complete: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR && $past(state_reg == S_CLEAR)) |-> $past(sts.clear_last))
        else $error("clearing pass left before the last entry");

endmodule

`default_nettype wire

[design/fpt_dpath.sv]
// Datapath: request registers, page table memory, entry update and result register.
`default_nettype none

module fpt_dpath #(
    parameter int PAGE_SHIFT     = fpt_pkg::PAGE_SHIFT_DEF,
    parameter int TABLE_PAGES    = fpt_pkg::TABLE_PAGES_DEF,
    parameter int HOST_ADDR_BITS = fpt_pkg::HOST_ADDR_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fpt_pkg::fpt_in_t  in_data,
    input  wire fpt_pkg::fpt_cmd_t cmd,
    output fpt_pkg::fpt_sts_t      sts,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output fpt_pkg::fpt_out_t      out_data
);

    localparam int VPW = fpt_pkg::ADDR_BITS - PAGE_SHIFT;      // virtual page number
    localparam int PW  = VPW + 1;                              // page plus run offset
    localparam int HPW = HOST_ADDR_BITS - PAGE_SHIFT;          // host page number
    localparam int IDX = $clog2(TABLE_PAGES);

    typedef struct packed {
        logic [HPW-1:0]                base;
        logic [fpt_pkg::BYTE_BITS-1:0] mtype;
        logic [fpt_pkg::BYTE_BITS-1:0] perm;
        logic [fpt_pkg::BYTE_BITS-1:0] attr;
    } entry_t;

    entry_t mem [TABLE_PAGES];

    logic [fpt_pkg::FUNC_BITS-1:0]  func_reg;
    logic [PW-1:0]                  dpage_reg;
    logic [PW-1:0]                  spage_reg;
    logic [fpt_pkg::COUNT_BITS-1:0] remain_reg;
    logic [HPW-1:0]                 hpage_reg;
    logic [PAGE_SHIFT-1:0]          ofs_reg;
    logic [fpt_pkg::BYTE_BITS-1:0]  type_reg;
    logic [fpt_pkg::BYTE_BITS-1:0]  perm_reg;
    logic [fpt_pkg::BYTE_BITS-1:0]  av_reg;
    logic [fpt_pkg::BYTE_BITS-1:0]  am_reg;
    logic                           fault_reg;
    logic [IDX-1:0]                 clr_addr_reg;
    entry_t                         rdata_reg;
    fpt_pkg::fpt_out_t              out_reg;
    logic                           out_valid_reg;

    logic                    dp_in_table;
    logic                    sp_in_table;
    entry_t                  wr_data;
    logic [IDX-1:0]          raddr;
    logic [IDX-1:0]          waddr;
    entry_t                  mem_wdata;
    logic                    mem_we;
    logic [HOST_ADDR_BITS-1:0] host_full;
    fpt_pkg::fpt_out_t       result;

    assign dp_in_table = dpage_reg < PW'(TABLE_PAGES);
    assign sp_in_table = spage_reg < PW'(TABLE_PAGES);

    always_comb
    begin
        sts            = '0;
        sts.clear_last = clr_addr_reg == IDX'(TABLE_PAGES - 1);
        sts.range_op   = func_reg inside {[fpt_pkg::FUNC_MAP:fpt_pkg::FUNC_ATTR]};
        sts.lookup_op  = func_reg inside {fpt_pkg::FUNC_TRANSLATE, fpt_pkg::FUNC_QUERY};
        sts.count_zero = remain_reg == '0;
        sts.page_out   = !dp_in_table || (func_reg == fpt_pkg::FUNC_REMAP && !sp_in_table);
        sts.out_free   = !out_valid_reg || out_ready;
    end

    // New entry contents for one page of a range request
    always_comb
    begin
        wr_data = rdata_reg;
        case (func_reg)
            fpt_pkg::FUNC_MAP:
            begin
                wr_data.base  = hpage_reg;
                wr_data.mtype = type_reg;
                wr_data.perm  = perm_reg;
                wr_data.attr  = av_reg;
            end
            fpt_pkg::FUNC_UNMAP:
            begin
                wr_data = '0;
            end
            fpt_pkg::FUNC_PROTECT:
            begin
                wr_data.perm = perm_reg;
            end
            fpt_pkg::FUNC_ATTR:
            begin
                wr_data.attr = (rdata_reg.attr & ~am_reg) | (av_reg & am_reg);
            end
            default:
            begin
                wr_data = rdata_reg;
            end
        endcase
    end

    assign raddr     = (func_reg == fpt_pkg::FUNC_REMAP) ? spage_reg[IDX-1:0]
                                                         : dpage_reg[IDX-1:0];
    assign waddr     = cmd.clear_wr ? clr_addr_reg : dpage_reg[IDX-1:0];
    assign mem_wdata = cmd.clear_wr ? entry_t'('0) : wr_data;
    assign mem_we    = cmd.clear_wr || cmd.wr;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= mem_wdata;
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Stored bases are page aligned, so the offset just fills the low bits
    assign host_full = {rdata_reg.base, ofs_reg};

    always_comb
    begin
        result = '0;
        case (func_reg)
            fpt_pkg::FUNC_TRANSLATE:
            begin
                if (dp_in_table && rdata_reg.base != '0)
                begin
                    result.host_addr = fpt_pkg::ADDR_BITS'(host_full);
                end
            end
            fpt_pkg::FUNC_QUERY:
            begin
                result.region_base = {dpage_reg[VPW-1:0], {PAGE_SHIFT{1'b0}}};
                if (dp_in_table)
                begin
                    result.out_type = rdata_reg.mtype;
                    result.out_perm = rdata_reg.perm;
                    result.out_attr = rdata_reg.attr;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
        result.range_fault = fault_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= in_data.func;
            dpage_reg  <= PW'(in_data.va[fpt_pkg::ADDR_BITS-1:PAGE_SHIFT]);
            spage_reg  <= PW'(in_data.src_va[fpt_pkg::ADDR_BITS-1:PAGE_SHIFT]);
            remain_reg <= in_data.run_pages;
            hpage_reg  <= HPW'(in_data.host_base[fpt_pkg::ADDR_BITS-1:PAGE_SHIFT]);
            ofs_reg    <= in_data.va[PAGE_SHIFT-1:0];
            type_reg   <= in_data.state_type;
            perm_reg   <= in_data.perm;
            av_reg     <= in_data.attr_value;
            am_reg     <= in_data.attr_mask;
        end
        else if (cmd.adv)
        begin
            dpage_reg  <= dpage_reg + PW'(1);
            spage_reg  <= spage_reg + PW'(1);
            remain_reg <= remain_reg - fpt_pkg::COUNT_BITS'(1);
            hpage_reg  <= hpage_reg + HPW'(1);
        end
        if (cmd.done)
        begin
            out_reg <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + IDX'(1);
            end
            if (cmd.load)
            begin
                fault_reg <= 1'b0;
            end
            else if (cmd.set_fault)
            begin
                fault_reg <= 1'b1;
            end
            if (cmd.done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_wr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr |-> dp_in_table)
        else $error("table write beyond the last page");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !out_valid_reg)
        else $error("result pending during the clearing pass");

endmodule

`default_nettype wire

[tb/flat_page_table_engine_tb.sv]
// Self-checking testbench for the flat page table engine: directed cases, random traffic, stalls.
`default_nettype none

module flat_page_table_engine_tb;

    import fpt_pkg::*;

    localparam int PG_SHIFT   = PAGE_SHIFT_DEF;
    localparam int PG_COUNT   = TABLE_PAGES_DEF;
    localparam int HOST_BITS  = HOST_ADDR_BITS_DEF;

    // Selector value the block leaves unused; it must return an all-zero beat.
    localparam logic [FUNC_BITS-1:0] FUNC_UNUSED = 3'd7;

    localparam logic [63:0] OFS_MASK  = (64'd1 << PG_SHIFT) - 64'd1;
    localparam logic [63:0] HOST_MASK = (HOST_BITS >= 64) ? {64{1'b1}}
                                                          : ((64'd1 << HOST_BITS) - 64'd1);

    // Reset clearing pass plus one full-table walk dominate; the rest is small.
    localparam int CYCLE_LIMIT = 3_000_000;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    fpt_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    fpt_out_t out_data;

    // Shadow copy of the page table, all zero after reset (Free, unmapped).
    bit [ADDR_BITS-1:0] pg_base [PG_COUNT];
    bit [BYTE_BITS-1:0] pg_type [PG_COUNT];
    bit [BYTE_BITS-1:0] pg_perm [PG_COUNT];
    bit [BYTE_BITS-1:0] pg_attr [PG_COUNT];

    // Replies owed by the block, oldest first.
    fpt_out_t table_replies[$];

    int send_idle_pct;
    int recv_idle_pct;
    int rx_hold;        // cycles the receiver must still hold off
    int mismatches;
    int cycle_count;

    flat_page_table_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the reply it produces.
    // Pages only ascend in a run, so once the destination or the source leaves
    // the table every later page is skipped as well: flag the fault and stop.
    function automatic fpt_out_t table_apply(fpt_in_t r);
        logic [63:0] vpage;
        logic [63:0] spage;
        logic [63:0] hbase;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] i;
        logic [63:0] sum;
        fpt_out_t    res;
        res   = '0;
        vpage = 64'(r.va) >> PG_SHIFT;
        spage = 64'(r.src_va) >> PG_SHIFT;
        hbase = 64'(r.host_base) & ~OFS_MASK;
        if (r.func <= FUNC_ATTR)
        begin
            for (i = 0; i < 64'(r.run_pages); i++)
            begin
                p = vpage + i;
                s = spage + i;
                if (p >= PG_COUNT || (r.func == FUNC_REMAP && s >= PG_COUNT))
                begin
                    res.range_fault = 1'b1;
                    break;
                end
                case (r.func)
                    FUNC_MAP:
                    begin
                        sum        = (hbase + (i << PG_SHIFT)) & HOST_MASK;
                        pg_base[p] = sum[ADDR_BITS-1:0];
                        pg_type[p] = r.state_type;
                        pg_perm[p] = r.perm;
                        pg_attr[p] = r.attr_value;
                    end
                    FUNC_REMAP:
                    begin
                        // Copy in ascending order: an earlier destination may be a later source.
                        pg_base[p] = pg_base[s];
                        pg_type[p] = pg_type[s];
                        pg_perm[p] = pg_perm[s];
                        pg_attr[p] = pg_attr[s];
                    end
                    FUNC_UNMAP:
                    begin
                        pg_base[p] = '0;
                        pg_type[p] = '0;
                        pg_perm[p] = '0;
                        pg_attr[p] = '0;
                    end
                    FUNC_PROTECT:
                        pg_perm[p] = r.perm;
                    default:
                        pg_attr[p] = (pg_attr[p] & ~r.attr_mask) | (r.attr_value & r.attr_mask);
                endcase
            end
        end
        else if (r.func == FUNC_TRANSLATE)
        begin
            if (vpage < PG_COUNT && pg_base[vpage] != '0)
            begin
                sum           = (64'(pg_base[vpage]) + (64'(r.va) & OFS_MASK)) & HOST_MASK;
                res.host_addr = sum[ADDR_BITS-1:0];
            end
        end
        else if (r.func == FUNC_QUERY)
        begin
            res.region_base = r.va & ~OFS_MASK[ADDR_BITS-1:0];
            if (vpage < PG_COUNT)
            begin
                res.out_type = pg_type[vpage];
                res.out_perm = pg_perm[vpage];
                res.out_attr = pg_attr[vpage];
            end
        end
        return res;
    endfunction

    function automatic logic [ADDR_BITS-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[ADDR_BITS-1:0];
    endfunction

    // Mostly a small hot window so lookups hit mapped pages, some near the top
    // of the table, some anywhere in the 48-bit space (beyond the table).
    function automatic logic [ADDR_BITS-1:0] pick_va(bit high_only);
        int unsigned roll;
        logic [63:0] pg;
        roll = high_only ? $urandom_range(99, 70) : $urandom_range(99);
        if (roll < 70)
            pg = 64'($urandom_range(63));
        else if (roll < 85)
            pg = 64'($urandom_range(PG_COUNT - 1, PG_COUNT - 36));
        else
            return rand48();
        return ADDR_BITS'((pg << PG_SHIFT) | (64'($urandom) & OFS_MASK));
    endfunction

    function automatic fpt_in_t random_request(bit lookups_only);
        fpt_in_t     r;
        int unsigned roll;
        bit          big;
        roll = $urandom_range(99);
        if (lookups_only)
            r.func = roll[0] ? FUNC_TRANSLATE : FUNC_QUERY;
        else if (roll < 15) r.func = FUNC_MAP;
        else if (roll < 25) r.func = FUNC_REMAP;
        else if (roll < 33) r.func = FUNC_UNMAP;
        else if (roll < 41) r.func = FUNC_PROTECT;
        else if (roll < 51) r.func = FUNC_ATTR;
        else if (roll < 75) r.func = FUNC_TRANSLATE;
        else if (roll < 97) r.func = FUNC_QUERY;
        else                r.func = FUNC_UNUSED;
        // Large runs only start near the top or beyond, keeping each walk short.
        big = ($urandom_range(99) < 5);
        roll = $urandom_range(99);
        if (big)
            r.run_pages = COUNT_BITS'($urandom_range(65536));
        else if (roll < 85)
            r.run_pages = COUNT_BITS'($urandom_range(8));
        else
            r.run_pages = COUNT_BITS'($urandom_range(64, 9));
        r.va     = pick_va(big);
        r.src_va = pick_va(1'b0);
        roll = $urandom_range(99);
        if (roll < 5)
            r.host_base = '0;
        else if (roll < 30)
            r.host_base = ADDR_BITS'($urandom_range(1 << 20));
        else if (roll < 50)
            r.host_base = {36'hFFF_FFFF_FF, 12'($urandom)};
        else
            r.host_base = rand48();
        r.state_type = BYTE_BITS'($urandom_range(255));
        r.perm       = BYTE_BITS'($urandom_range(255));
        r.attr_value = BYTE_BITS'($urandom_range(255));
        r.attr_mask  = BYTE_BITS'($urandom_range(255));
        return r;
    endfunction

    function automatic fpt_in_t make_req(logic [FUNC_BITS-1:0] f, logic [ADDR_BITS-1:0] va,
                                         logic [ADDR_BITS-1:0] src, int unsigned cnt,
                                         logic [ADDR_BITS-1:0] hb, logic [7:0] st,
                                         logic [7:0] pm, logic [7:0] av, logic [7:0] am);
        fpt_in_t r;
        r.func       = f;
        r.va         = va;
        r.src_va     = src;
        r.run_pages  = COUNT_BITS'(cnt);
        r.host_base  = hb;
        r.state_type = st;
        r.perm       = pm;
        r.attr_value = av;
        r.attr_mask  = am;
        return r;
    endfunction

    // Offer one request beat: idle at random first, then hold valid until accepted.
    // Valid stays high after acceptance until the next falling edge, where the
    // next call either drops it or replaces the payload.
    task automatic send_req(fpt_in_t r);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = r;
        do
            @(posedge clk);
        while (!(in_ready && rst_n));
        table_replies.push_back(table_apply(r));
    endtask

    task automatic log_failure(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
    endtask

    task automatic compare_field(string name, logic [ADDR_BITS-1:0] want,
                                 logic [ADDR_BITS-1:0] got);
        if (want !== got)
            log_failure($sformatf("%s expected 0x%0h actual 0x%0h", name, want, got));
    endtask

    // Check every result beat against the oldest owed reply.
    always @(posedge clk)
    begin
        fpt_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (table_replies.size() == 0)
                log_failure("result beat with no reply pending");
            else
            begin
                want = table_replies.pop_front();
                compare_field("host_addr",   want.host_addr,   out_data.host_addr);
                compare_field("region_base", want.region_base, out_data.region_base);
                compare_field("out_type",    48'(want.out_type),    48'(out_data.out_type));
                compare_field("out_perm",    48'(want.out_perm),    48'(out_data.out_perm));
                compare_field("out_attr",    48'(want.out_attr),    48'(out_data.out_attr));
                compare_field("range_fault", 48'(want.range_fault), 48'(out_data.range_fault));
            end
        end
    end

    // Receiver: honor a requested hold-off first, otherwise stall at random.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_ready = 1'b0;
                rx_hold--;
            end
            else
                out_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Map, translate and query: offsets, wrapping host bases, base zero, beyond-table lookups.
    task automatic test_map_and_lookup();
        // Unaligned va and host_base: low bits must be dropped.
        send_req(make_req(FUNC_MAP, 48'h0000_0000_0123, '0, 4, 48'h0000_0ABC_D123,
                          8'hFF, 8'h00, 8'hA5, 8'h00));
        send_req(make_req(FUNC_TRANSLATE, 48'h0000_0000_1FFF, '0, 0, '0, 0, 0, 0, 0));
        send_req(make_req(FUNC_QUERY, 48'h0000_0000_2ABC, '0, 0, '0, 0, 0, 0, 0));
        // Host base at the top of the space: the second page wraps to base zero.
        send_req(make_req(FUNC_MAP, 48'h0000_0001_0000, '0, 3, 48'hFFFF_FFFF_FABC,
                          8'h01, 8'hFF, 8'h00, 8'hFF));
        send_req(make_req(FUNC_TRANSLATE, 48'h0000_0001_0FFF, '0, 0, '0, 0, 0, 0, 0));
        send_req(make_req(FUNC_TRANSLATE, 48'h0000_0001_1800, '0, 0, '0, 0, 0, 0, 0));
        // Map with host base zero reads back as unmapped.
        send_req(make_req(FUNC_MAP, 48'h0000_0001_4000, '0, 1, 48'h0,
                          8'h07, 8'h03, 8'h0F, 8'h00));
        send_req(make_req(FUNC_TRANSLATE, 48'h0000_0001_4555, '0, 0, '0, 0, 0, 0, 0));
        // Beyond the table: query keeps the region base, translate gives zero.
        send_req(make_req(FUNC_QUERY, 48'hFFFF_FFFF_FFFF, '0, 0, '0, 0, 0, 0, 0));
        send_req(make_req(FUNC_TRANSLATE, 48'hFFFF_FFFF_FFFF, '0, 0, '0, 0, 0, 0, 0));
        // Unused selector with every field set changes nothing.
        send_req(make_req(FUNC_UNUSED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 65536,
                          48'hFFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Protect, masked attribute update, overlapping remap, unmap, zero-length runs.
    task automatic test_range_updates();
        send_req(make_req(FUNC_PROTECT, 48'h0, '0, 2, '0, 0, 8'h5A, 0, 0));
        send_req(make_req(FUNC_ATTR, 48'h0000_0000_1000, '0, 3, '0, 0, 0, 8'hF0, 8'h3C));
        send_req(make_req(FUNC_QUERY, 48'h0000_0000_3000, '0, 0, '0, 0, 0, 0, 0));
        // Destination one page above the source: page 0 propagates up the run.
        send_req(make_req(FUNC_REMAP, 48'h0000_0000_1000, 48'h0000_0000_0FFF, 4, '0,
                          0, 0, 0, 0));
        send_req(make_req(FUNC_QUERY, 48'h0000_0000_4000, '0, 0, '0, 0, 0, 0, 0));
        // Source beyond the table: every page skipped, fault raised.
        send_req(make_req(FUNC_REMAP, 48'h0000_0001_E000, 48'hFFFF_FFFF_FFFF, 2, '0,
                          0, 0, 0, 0));
        send_req(make_req(FUNC_UNMAP, 48'h0000_0000_1000, '0, 2, '0, 0, 0, 0, 0));
        send_req(make_req(FUNC_TRANSLATE, 48'h0000_0000_1234, '0, 0, '0, 0, 0, 0, 0));
        send_req(make_req(FUNC_MAP, 48'h0000_0002_8000, '0, 0, 48'h1000, 8'h02, 0, 0, 0));
    endtask

    // Runs that cross the end of the table, and one walk over the whole table.
    task automatic test_table_edges();
        send_req(make_req(FUNC_MAP, 48'h0000_0FFF_E000, '0, 5, 48'h0000_8000_0000,
                          8'h03, 8'h81, 8'h42, 8'h00));
        send_req(make_req(FUNC_QUERY, 48'h0000_0FFF_FFFF, '0, 0, '0, 0, 0, 0, 0));
        send_req(make_req(FUNC_UNMAP, 48'h0000_0FFF_A000, '0, 65536, '0, 0, 0, 0, 0));
        send_req(make_req(FUNC_TRANSLATE, 48'h0000_0FFF_F001, '0, 0, '0, 0, 0, 0, 0));
        send_req(make_req(FUNC_MAP, 48'h0, '0, 65536, rand48(), 8'h05, 8'h07, 8'h11, 8'h00));
        send_req(make_req(FUNC_TRANSLATE, 48'h0000_0FFF_FABC, '0, 0, '0, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(int count, int s_pct, int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
            send_req(random_request(1'b0));
    endtask

    // Hold the result side for a long stretch while lookups keep coming,
    // so the block fills and drops in_ready.
    task automatic test_output_stall();
        rx_hold = 400;
        repeat (24)
            send_req(random_request(1'b1));
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        rx_hold       = 0;
        mismatches    = 0;
        cycle_count   = 0;
        send_idle_pct = 31;
        recv_idle_pct = 86;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_map_and_lookup();
        test_range_updates();
        test_table_edges();
        test_random_traffic(640, 31, 86);
        test_random_traffic(640, 86, 31);
        test_random_traffic(620, 0, 0);
        test_output_stall();

        // Drop valid after the final beat, drain all owed replies, then linger
        // a little for any stray beat.
        @(negedge clk);
        in_valid = 1'b0;
        while (table_replies.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
